// File: sv/depth_pixel_backprojection_defines.svh
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_defines
// assertion macros of the back-projection rtl
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define DPB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DPB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: sv/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// types, register codes and reset values of the depth pixel back-projection
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int unsigned NumStages = 5;
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgInvDepthScale = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInvFocalX     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgInvFocalY     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCenterX       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCenterY       = 3'd4;

  // register reset values
  localparam logic [31:0] InvDepthScaleRst = 32'd4294967;
  localparam logic [31:0] InvFocalXRst     = 32'd8291443;
  localparam logic [31:0] InvFocalYRst     = 32'd8291443;
  localparam logic [15:0] CenterXRst       = 16'd5208;
  localparam logic [15:0] CenterYRst       = 16'd4056;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0]        pos_z;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
  } point_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  // per-stage load enables, one bit per pipeline register stage
  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctrl_t;

endpackage

// File: sv/dpb_stream_if.sv
// ----------------------------------------------------------------------------
// dpb_stream_if
// valid/ready stream channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface dpb_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: sv/dpb_front.sv
// ----------------------------------------------------------------------------
// dpb_front
// first stage: metric depth and pixel offsets from the principal point
// ----------------------------------------------------------------------------
module dpb_front (
  input  logic                clk_i,
  input  dpb_pkg::pipe_ctrl_t ctrl_i,
  input  dpb_pkg::pixel_t     pix_i,
  input  logic [31:0]         inv_depth_scale_i,
  input  logic [15:0]         center_x_i,
  input  logic [15:0]         center_y_i,
  output logic [31:0]         z_o,
  output logic [15:0]         mag_x_o,
  output logic                neg_x_o,
  output logic [15:0]         mag_y_o,
  output logic                neg_y_o,
  output dpb_pkg::color_t     color_o
);

  logic [47:0] zprod;
  logic [15:0] col_q4;
  logic [15:0] row_q4;
  logic        neg_x_d;
  logic        neg_y_d;
  logic [15:0] mag_x_d;
  logic [15:0] mag_y_d;

  logic [31:0]     z_q;
  logic [15:0]     mag_x_q;
  logic            neg_x_q;
  logic [15:0]     mag_y_q;
  logic            neg_y_q;
  dpb_pkg::color_t color_q;

  assign zprod  = {32'd0, pix_i.depth} * {16'd0, inv_depth_scale_i};
  assign col_q4 = {pix_i.col, 4'd0};
  assign row_q4 = {pix_i.row, 4'd0};

  // offset magnitude never exceeds 16 bits since both sides are below 2^16
  assign neg_x_d = col_q4 < center_x_i;
  assign neg_y_d = row_q4 < center_y_i;
  assign mag_x_d = neg_x_d ? (center_x_i - col_q4) : (col_q4 - center_x_i);
  assign mag_y_d = neg_y_d ? (center_y_i - row_q4) : (row_q4 - center_y_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      z_q           <= zprod[47:16];
      mag_x_q       <= mag_x_d;
      neg_x_q       <= neg_x_d;
      mag_y_q       <= mag_y_d;
      neg_y_q       <= neg_y_d;
      color_q.blue  <= pix_i.blue;
      color_q.green <= pix_i.green;
      color_q.red   <= pix_i.red;
    end
  end

  assign z_o     = z_q;
  assign mag_x_o = mag_x_q;
  assign neg_x_o = neg_x_q;
  assign mag_y_o = mag_y_q;
  assign neg_y_o = neg_y_q;
  assign color_o = color_q;

endmodule

// File: sv/dpb_axis.sv
// ----------------------------------------------------------------------------
// dpb_axis
// four-stage projection of one axis: offset*z, split multiply by the
// reciprocal focal length, recombine, floor shift with sign
// ----------------------------------------------------------------------------
module dpb_axis (
  input  logic                clk_i,
  input  dpb_pkg::pipe_ctrl_t ctrl_i,
  input  logic [15:0]         mag_i,
  input  logic                neg_i,
  input  logic [31:0]         z_i,
  input  logic [31:0]         recip_i,
  output logic signed [47:0]  pos_o
);

  logic [47:0] m_q;
  logic        neg2_q;
  logic [63:0] pl_q;
  logic [47:0] ph_q;
  logic        neg3_q;
  logic [49:0] high_d;
  logic [49:0] high_q;
  logic        rem_d;
  logic        rem_q;
  logic        neg4_q;
  logic [47:0] quo;
  logic [47:0] pos_d;
  logic [47:0] pos_q;

  // stage 2: offset magnitude times z, Q.20
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      m_q    <= {32'd0, mag_i} * {16'd0, z_i};
      neg2_q <= neg_i;
    end
  end

  // stage 3: partial products of the 48x32 multiply
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      pl_q   <= {32'd0, m_q[31:0]} * {32'd0, recip_i};
      ph_q   <= {32'd0, m_q[47:32]} * {16'd0, recip_i};
      neg3_q <= neg2_q;
    end
  end

  // stage 4: upper part of the product, sticky bit of dropped fraction
  assign high_d = {2'd0, ph_q} + {18'd0, pl_q[63:32]};
  assign rem_d  = (high_d[3:0] != 4'd0) || (pl_q[31:0] != 32'd0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      high_q <= high_d;
      rem_q  <= rem_d;
      neg4_q <= neg3_q;
    end
  end

  // stage 5: -(q + rem) written as ~q + !rem for floor on negatives
  assign quo   = {2'd0, high_q[49:4]};
  assign pos_d = neg4_q ? (~quo + {47'd0, ~rem_q}) : quo;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[4]) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = signed'(pos_q);

endmodule

// File: sv/depth_pixel_backprojection.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// pinhole back-projection of rgb-d pixels to colored fixed-point 3-d points
// ----------------------------------------------------------------------------
// Five-stage pipeline taking one pixel per clock unless the output stalls.
// Stage 1 forms z and the principal-point offsets, stages 2-5 run the two
// axis multipliers (offset*z, split 48x32 reciprocal product, recombine,
// floor with sign). Each stage holds its own valid bit and loads when empty
// or draining, so bubbles close up under output back-pressure. Pixels with
// zero depth or outside the frame are taken and produce no point. The user
// must write configuration registers through the write port only while no
// pixel is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "depth_pixel_backprojection_defines.svh"

module depth_pixel_backprojection #(
  parameter int unsigned MAX_WIDTH  = dpb_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = dpb_pkg::MaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dpb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dpb_pkg::CfgDataW-1:0]  cfg_data_i,
  dpb_stream_if.sink                    pix_i,
  dpb_stream_if.source                  pt_o
);

  localparam int unsigned NS = dpb_pkg::NumStages;

  logic [31:0] inv_depth_scale_q;
  logic [31:0] inv_focal_x_q;
  logic [31:0] inv_focal_y_q;
  logic [15:0] center_x_q;
  logic [15:0] center_y_q;

  dpb_pkg::pixel_t    pix;
  dpb_pkg::pipe_ctrl_t ctrl;
  logic [NS-1:0]      valid_q;
  logic [NS-1:0]      valid_d;
  logic               keep;

  logic [31:0]        z1;
  logic [15:0]        mag_x;
  logic               neg_x;
  logic [15:0]        mag_y;
  logic               neg_y;
  dpb_pkg::color_t    color1;
  logic [31:0]        z_q     [NS-1];
  dpb_pkg::color_t    color_q [NS-1];
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_depth_scale_q <= dpb_pkg::InvDepthScaleRst;
      inv_focal_x_q     <= dpb_pkg::InvFocalXRst;
      inv_focal_y_q     <= dpb_pkg::InvFocalYRst;
      center_x_q        <= dpb_pkg::CenterXRst;
      center_y_q        <= dpb_pkg::CenterYRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpb_pkg::CfgInvDepthScale: inv_depth_scale_q <= cfg_data_i;
        dpb_pkg::CfgInvFocalX:     inv_focal_x_q     <= cfg_data_i;
        dpb_pkg::CfgInvFocalY:     inv_focal_y_q     <= cfg_data_i;
        dpb_pkg::CfgCenterX:       center_x_q        <= cfg_data_i[15:0];
        dpb_pkg::CfgCenterY:       center_y_q        <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign pix = pix_i.data;

  assign keep = (pix.depth != 16'd0)
             && ({20'd0, pix.col} < 32'(MAX_WIDTH))
             && ({20'd0, pix.row} < 32'(MAX_HEIGHT));

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ctrl.en[NS-1] = !valid_q[NS-1] || pt_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ctrl.en[k] = !valid_q[k] || ctrl.en[k+1];
    end
  end

  always_comb begin
    valid_d[0] = pix_i.valid && keep;
    for (int k = 1; k < NS; k++) begin
      valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (ctrl.en[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  assign pix_i.ready = ctrl.en[0];

  dpb_front u_front (
    .clk_i             (clk_i),
    .ctrl_i            (ctrl),
    .pix_i             (pix),
    .inv_depth_scale_i (inv_depth_scale_q),
    .center_x_i        (center_x_q),
    .center_y_i        (center_y_q),
    .z_o               (z1),
    .mag_x_o           (mag_x),
    .neg_x_o           (neg_x),
    .mag_y_o           (mag_y),
    .neg_y_o           (neg_y),
    .color_o           (color1)
  );

  dpb_axis u_axis_x (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .mag_i   (mag_x),
    .neg_i   (neg_x),
    .z_i     (z1),
    .recip_i (inv_focal_x_q),
    .pos_o   (pos_x)
  );

  dpb_axis u_axis_y (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .mag_i   (mag_y),
    .neg_i   (neg_y),
    .z_i     (z1),
    .recip_i (inv_focal_y_q),
    .pos_o   (pos_y)
  );

  // z and color ride along with the axis stages
  always_ff @(posedge clk_i) begin
    if (ctrl.en[1]) begin
      z_q[0]     <= z1;
      color_q[0] <= color1;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (ctrl.en[k+1]) begin
        z_q[k]     <= z_q[k-1];
        color_q[k] <= color_q[k-1];
      end
    end
  end

  assign pt_o.valid          = valid_q[NS-1];
  assign pt_o.data.pos_x     = pos_x;
  assign pt_o.data.pos_y     = pos_y;
  assign pt_o.data.pos_z     = z_q[NS-2];
  assign pt_o.data.out_blue  = color_q[NS-2].blue;
  assign pt_o.data.out_green = color_q[NS-2].green;
  assign pt_o.data.out_red   = color_q[NS-2].red;

  `DPB_ASSERT_NEXT(a_drop_no_depth, clk_i, rst_ni,
    pix_i.valid && pix_i.ready && (pix.depth == 16'd0), !valid_q[0],
    "pixel without depth entered the pipeline")

  `DPB_ASSERT_NEXT(a_stall_keeps_item, clk_i, rst_ni,
    valid_q[2] && !ctrl.en[2], valid_q[2] && $stable(z_q[1]),
    "stalled stage lost or changed its item")

  `DPB_ASSERT_IMPL(a_bubble_fills, clk_i, rst_ni,
    !valid_q[1], ctrl.en[1] && ctrl.en[0],
    "empty stage does not load")

  `DPB_ASSERT_NEXT(a_advance_moves, clk_i, rst_ni,
    valid_q[3] && ctrl.en[4], valid_q[4],
    "item vanished between stages")

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the rgb-d pixel back-projection pipeline: a table of
// directed pixels and register writes, then random pixels under several
// camera settings and handshake idling patterns, every point checked against its
// table entry or an in-bench fixed-point back-projection
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [dpb_pkg::CfgIdxW-1:0] cfg_idx_t;

  // indexes that map to no register
  localparam cfg_idx_t    CfgIdxUnusedLo = dpb_pkg::CfgCenterY + 3'd1;
  localparam cfg_idx_t    CfgIdxUnusedHi = '1;
  localparam int unsigned DrainCycles    = dpb_pkg::NumStages + 3;
  localparam int unsigned PixelsPerSeg   = 76;

  typedef enum int unsigned {
    CamTypical,
    CamRandom,
    CamExtreme
  } cam_kind_e;

  typedef struct packed {
    logic [31:0] inv_scale;
    logic [31:0] inv_fx;
    logic [31:0] inv_fy;
    logic [15:0] cx;
    logic [15:0] cy;
  } camera_t;

  typedef struct {
    bit                       is_cfg;
    cfg_idx_t                 idx;
    logic [31:0]              wdata;
    dpb_pkg::pixel_t          pix;
    bit                       typed;
    bit                       typed_has;
    dpb_pkg::point_t          typed_pt;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  cfg_idx_t    cfg_idx;
  logic [31:0] cfg_data;

  dpb_stream_if #(.payload_t(dpb_pkg::pixel_t)) pix_if ();
  dpb_stream_if #(.payload_t(dpb_pkg::point_t)) pt_if ();

  depth_pixel_backprojection u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if.sink),
    .pt_o       (pt_if.source)
  );

  camera_t         cam;
  dpb_pkg::point_t pending_points[$];
  stim_row_t       dir_rows[$];
  int unsigned     src_idle_pct;
  int unsigned     sink_idle_pct;
  int unsigned     n_fail;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // back-projection predictor
  // ---------------------------------------------------------------------------

  // floor(offset_q4 * z_q16 * recip_q32 / 2^36), kept as a 48-bit pattern
  function automatic logic signed [47:0] axis_point(logic [11:0] pix, logic [15:0] ctr,
                                                     logic [31:0] z, logic [31:0] recip);
    logic signed [95:0] off;
    logic signed [95:0] zw;
    logic signed [95:0] rw;
    logic signed [95:0] prod;
    off  = $signed({80'd0, pix, 4'd0}) - $signed({80'd0, ctr});
    zw   = $signed({64'd0, z});
    rw   = $signed({64'd0, recip});
    prod = (off * zw * rw) >>> 36;
    return prod[47:0];
  endfunction

  function automatic bit backproject(input dpb_pkg::pixel_t p, output dpb_pkg::point_t pt);
    logic [47:0] zp;
    logic [31:0] z;
    pt = '0;
    if (p.depth == 16'd0 || p.col >= dpb_pkg::MaxWidth || p.row >= dpb_pkg::MaxHeight) begin
      return 1'b0;
    end
    zp           = {32'd0, p.depth} * {16'd0, cam.inv_scale};
    z            = zp[47:16];
    pt.pos_x     = axis_point(p.col, cam.cx, z, cam.inv_fx);
    pt.pos_y     = axis_point(p.row, cam.cy, z, cam.inv_fy);
    pt.pos_z     = z;
    pt.out_blue  = p.blue;
    pt.out_green = p.green;
    pt.out_red   = p.red;
    return 1'b1;
  endfunction

  function automatic void shadow_reg(cfg_idx_t idx, logic [31:0] data);
    case (idx)
      dpb_pkg::CfgInvDepthScale: cam.inv_scale = data;
      dpb_pkg::CfgInvFocalX:     cam.inv_fx    = data;
      dpb_pkg::CfgInvFocalY:     cam.inv_fy    = data;
      dpb_pkg::CfgCenterX:       cam.cx        = data[15:0];
      dpb_pkg::CfgCenterY:       cam.cy        = data[15:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // point checker
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %h actual %h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    dpb_pkg::point_t want;
    dpb_pkg::point_t got;
    if (rst_ni && pt_if.valid && pt_if.ready) begin
      got = pt_if.data;
      if (pending_points.size() == 0) begin
        $error("point transfer with none pending: %h", got);
        n_fail++;
      end else begin
        want = pending_points.pop_front();
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("pos_z", 48'(want.pos_z), 48'(got.pos_z));
        check_field("out_blue", 48'(want.out_blue), 48'(got.out_blue));
        check_field("out_green", 48'(want.out_green), 48'(got.out_green));
        check_field("out_red", 48'(want.out_red), 48'(got.out_red));
      end
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin
    pt_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // returns at the rising edge of the transfer
  task automatic send_and_expect(input dpb_pkg::pixel_t p, input bit typed,
                                 input bit typed_has, input dpb_pkg::point_t typed_pt);
    dpb_pkg::point_t pt;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_if.data  = p;
    pix_if.valid = 1'b1;
    do @(posedge clk_i); while (!pix_if.ready);
    if (typed) begin
      if (typed_has) pending_points = {pending_points, typed_pt};
    end else if (backproject(p, pt)) begin
      pending_points = {pending_points, pt};
    end
  endtask

  // all points out, then let dropped pixels clear the pipeline
  task automatic wait_idle();
    @(negedge clk_i);
    pix_if.valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    shadow_reg(idx, data);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic program_camera(cam_kind_e kind);
    logic [31:0] scale;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [15:0] cx;
    logic [15:0] cy;
    case (kind)
      CamTypical: begin
        scale = $urandom_range(32'h0100_0000, 32'h0010_0000);
        fx    = $urandom_range(32'h0200_0000, 32'h0020_0000);
        fy    = $urandom_range(32'h0200_0000, 32'h0020_0000);
        cx    = 16'($urandom_range(16'hffff));
        cy    = 16'($urandom_range(16'hffff));
      end
      CamRandom: begin
        scale = $urandom;
        fx    = $urandom;
        fy    = $urandom;
        cx    = 16'($urandom);
        cy    = 16'($urandom);
      end
      default: begin
        scale = $urandom_range(1) ? '1 : '0;
        fx    = $urandom_range(1) ? '1 : '0;
        fy    = $urandom_range(1) ? '1 : '0;
        cx    = $urandom_range(1) ? '1 : '0;
        cy    = $urandom_range(1) ? '1 : '0;
      end
    endcase
    write_reg(dpb_pkg::CfgInvDepthScale, scale);
    write_reg(dpb_pkg::CfgInvFocalX, fx);
    write_reg(dpb_pkg::CfgInvFocalY, fy);
    // junk in the bits above the 16-bit centers
    write_reg(dpb_pkg::CfgCenterX, {16'($urandom), cx});
    write_reg(dpb_pkg::CfgCenterY, {16'($urandom), cy});
    write_reg(cfg_idx_t'($urandom_range(CfgIdxUnusedHi, CfgIdxUnusedLo)), $urandom);
  endtask

  function automatic dpb_pkg::pixel_t random_pixel();
    dpb_pkg::pixel_t p;
    int unsigned     pick;
    p.blue  = 8'($urandom);
    p.green = 8'($urandom);
    p.red   = 8'($urandom);
    pick    = $urandom_range(9);
    p.col   = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hfff : 12'($urandom_range(4095));
    pick    = $urandom_range(9);
    p.row   = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hfff : 12'($urandom_range(4095));
    pick    = $urandom_range(99);
    if (pick < 8) p.depth = 16'd0;
    else if (pick < 40) p.depth = 16'($urandom_range(255, 1));
    else p.depth = 16'($urandom_range(65535, 1));
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------

  function automatic stim_row_t pix_row(int c, int r, int d, int b, int g, int rd);
    stim_row_t row;
    row           = '{default: '0};
    row.pix.col   = 12'(c);
    row.pix.row   = 12'(r);
    row.pix.depth = 16'(d);
    row.pix.blue  = 8'(b);
    row.pix.green = 8'(g);
    row.pix.red   = 8'(rd);
    return row;
  endfunction

  function automatic void add_pix(int c, int r, int d, int b, int g, int rd);
    dir_rows = {dir_rows, pix_row(c, r, d, b, g, rd)};
  endfunction

  // no measurement: taken, no point
  function automatic void add_none(int c, int r, int d, int b, int g, int rd);
    stim_row_t row;
    row       = pix_row(c, r, d, b, g, rd);
    row.typed = 1'b1;
    dir_rows  = {dir_rows, row};
  endfunction

  // zero depth scale: point at the origin, color passed through
  function automatic void add_origin(int c, int r, int d, int b, int g, int rd);
    stim_row_t row;
    row                    = pix_row(c, r, d, b, g, rd);
    row.typed              = 1'b1;
    row.typed_has          = 1'b1;
    row.typed_pt.out_blue  = 8'(b);
    row.typed_pt.out_green = 8'(g);
    row.typed_pt.out_red   = 8'(rd);
    dir_rows               = {dir_rows, row};
  endfunction

  function automatic void add_cfg(cfg_idx_t idx, logic [31:0] data);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.wdata  = data;
    dir_rows   = {dir_rows, row};
  endfunction

  function automatic void build_dir_rows();
    add_pix(0, 0, 1, 0, 0, 0);
    add_pix(4095, 4095, 65535, 255, 255, 255);
    add_pix(0, 4095, 65535, 8'ha5, 8'h5a, 8'h0f);
    add_pix(4095, 0, 1, 8'h5a, 8'ha5, 8'hf0);
    add_pix(325, 253, 1000, 1, 2, 3);
    add_pix(326, 254, 1000, 4, 5, 6);
    add_none(4095, 4095, 0, 255, 255, 255);
    add_none(0, 0, 0, 0, 0, 0);
    add_cfg(CfgIdxUnusedLo, '1);
    add_cfg(CfgIdxUnusedHi, '1);
    add_pix(100, 200, 3000, 7, 8, 9);
    add_cfg(dpb_pkg::CfgCenterX, 32'hffff_0000);
    add_cfg(dpb_pkg::CfgCenterY, 32'hffff_ffff);
    add_pix(0, 0, 65535, 10, 11, 12);
    add_pix(4095, 4095, 65535, 13, 14, 15);
    add_cfg(dpb_pkg::CfgInvDepthScale, '0);
    add_origin(4095, 4095, 65535, 255, 255, 255);
    add_origin(0, 0, 1, 0, 0, 0);
    add_origin(2048, 1024, 32768, 8'h80, 8'h40, 8'h20);
    add_cfg(dpb_pkg::CfgInvDepthScale, '1);
    add_cfg(dpb_pkg::CfgInvFocalX, '1);
    add_cfg(dpb_pkg::CfgInvFocalY, '1);
    add_pix(0, 0, 65535, 1, 1, 1);
    add_pix(4095, 4095, 65535, 2, 2, 2);
    add_pix(4095, 0, 65535, 3, 3, 3);
    add_cfg(dpb_pkg::CfgCenterX, '0);
    add_pix(4095, 4095, 65535, 4, 4, 4);
    add_cfg(dpb_pkg::CfgInvFocalX, '0);
    add_cfg(dpb_pkg::CfgInvFocalY, '0);
    add_pix(1234, 2345, 4321, 5, 6, 7);
  endfunction

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    dpb_pkg::pixel_t p;
    int unsigned     sent;
    bit              paused;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    pix_if.valid  = 1'b0;
    pix_if.data   = '0;
    pt_if.ready   = 1'b0;
    n_fail        = 0;
    src_idle_pct  = 21;
    sink_idle_pct = 77;
    cam           = '{dpb_pkg::InvDepthScaleRst, dpb_pkg::InvFocalXRst,
                      dpb_pkg::InvFocalYRst, dpb_pkg::CenterXRst, dpb_pkg::CenterYRst};
    build_dir_rows();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      end else begin
        send_and_expect(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].typed_has,
                        dir_rows[i].typed_pt);
      end
    end

    for (int seg = 0; seg < 9; seg++) begin
      src_idle_pct  = (seg < 3) ? 21 : (seg < 6) ? 77 : 0;
      sink_idle_pct = (seg < 3) ? 77 : (seg < 6) ? 21 : 0;
      wait_idle();
      program_camera(cam_kind_e'(seg % 3));
      sent   = 0;
      paused = 1'b0;
      while (sent < PixelsPerSeg) begin
        // hold the source until the pipeline has fully drained
        if (!paused && sent == PixelsPerSeg / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        p = random_pixel();
        send_and_expect(p, 1'b0, 1'b0, '0);
        sent++;
      end
    end

    wait_idle();
    if (n_fail == 0) begin
      $display("[depth_pixel_backprojection] OK");
    end else begin
      $display("[depth_pixel_backprojection] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[depth_pixel_backprojection] ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/dpb_pkg.sv
sv/dpb_stream_if.sv
sv/dpb_front.sv
sv/dpb_axis.sv
sv/depth_pixel_backprojection.sv
test/tb_top.sv
